// ===== src/bfpa_pkg.sv =====
// Shared types and status codes for the best-fit partition allocator.
package bfpa_pkg;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StUsedFull = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFreeFull = 3'd4;

  localparam logic ModeAlloc   = 1'b0;
  localparam logic ModeReclaim = 1'b1;

  localparam logic [15:0] MinBlockReset = 16'd100;

  typedef struct packed {
    logic        mode;
    logic [7:0]  job_name;
    logic [16:0] request_length;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] block_start;
    logic [16:0] block_size;
  } rsp_t;

endpackage

// ===== src/best_fit_partition_allocator_unit.sv =====
// Best-fit partition allocator: free and used tables in synchronous RAMs, scan sequencer.
//
//   channel  | signals                        | beat
//   ---------+--------------------------------+-----------------------------
//   request  | in_valid_i/in_ready_o/in_data_i   | one allocate or reclaim
//   response | out_valid_o/out_ready_i/out_data_o | one status/start/size
//   config   | cfg_we_i/cfg_wdata_i           | min_block write
//
// Allocate: one free-RAM scan, then the update state.
// Reclaim: used scan, free scan, update; a miss or a zero-size entry ends after the used scan.
// Rate is set by the single read port of each table, one entry per cycle.
// Reset empties the used table; only free entry 0 is valid, and it reads as the
// whole pool until first written. A new request is taken once the previous result
// has moved into the output register; a stalled output holds the next result back.
module best_fit_partition_allocator_unit
  import bfpa_pkg::*;
#(
  parameter int FREE_ENTRIES = 10,
  parameter int USED_ENTRIES = 10,
  parameter int POOL_SIZE    = 102400
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);

  localparam int FAW  = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int UAW  = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
  localparam int MAXN = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int CW   = $clog2(MAXN + 1);
  localparam logic [CW-1:0] FN = CW'(FREE_ENTRIES);
  localparam logic [CW-1:0] UN = CW'(USED_ENTRIES);
  localparam logic [16:0] PoolSz = 17'(POOL_SIZE);

  typedef enum logic [2:0] {
    S_IDLE, S_USCAN, S_FSCAN, S_DECIDE, S_RESP
  } state_e;

  typedef struct packed {
    logic [16:0] start;
    logic [16:0] size;
  } fent_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [16:0] start;
    logic [16:0] size;
  } uent_t;

  fent_t fmem [FREE_ENTRIES];
  uent_t umem [USED_ENTRIES];
  fent_t f_rd_q;
  uent_t u_rd_q;

  state_e      state_q;
  logic [CW-1:0] cnt_q, ridx_q;
  logic        rv_q, rvl_q;
  logic        mode_q;
  logic [7:0]  name_q;
  logic [16:0] ad_q;
  logic [15:0] min_block_q;
  logic [FREE_ENTRIES-1:0] fvalid_q;
  logic [USED_ENTRIES-1:0] uvalid_q;
  logic        f0w_q;
  logic        b_fnd_q;
  logic [FAW-1:0] b_idx_q;
  logic [16:0] b_start_q, b_size_q;
  logic        u_fnd_q;
  logic [UAW-1:0] u_idx_q;
  logic [16:0] s_q, z_q;
  logic        lo_fnd_q, hi_fnd_q;
  logic [FAW-1:0] lo_idx_q, hi_idx_q;
  logic [16:0] lo_start_q, lo_size_q, hi_size_q;
  rsp_t        res_q, out_q;
  logic        out_valid_q;

  logic        fw_en, uw_en;
  logic [FAW-1:0] fw_addr;
  logic [UAW-1:0] uw_addr;
  fent_t       fw_data;
  uent_t       uw_data;

  logic        issue_f, issue_u;
  logic [16:0] f_start, f_size, f_end, z_end;
  logic [16:0] req_ad;
  logic        fslot_ok, uslot_ok;
  logic [FAW-1:0] fslot;
  logic [UAW-1:0] uslot;

  assign issue_f = (state_q == S_FSCAN) && (cnt_q < FN);
  assign issue_u = (state_q == S_USCAN) && (cnt_q < UN);

  always_ff @(posedge clk_i) begin
    if (issue_f) f_rd_q <= fmem[cnt_q[FAW-1:0]];
    if (issue_u) u_rd_q <= umem[cnt_q[UAW-1:0]];
    if (fw_en) fmem[fw_addr] <= fw_data;
    if (uw_en) umem[uw_addr] <= uw_data;
  end

  // Entry 0 holds the whole pool until it is first written.
  always_comb begin
    if (ridx_q == '0 && !f0w_q) begin
      f_start = '0;
      f_size  = PoolSz;
    end else begin
      f_start = f_rd_q.start;
      f_size  = f_rd_q.size;
    end
  end
  assign f_end = f_start + f_size;
  assign z_end = s_q + z_q;

  assign req_ad = (in_data_i.request_length > {1'b0, min_block_q}) ?
                  in_data_i.request_length : {1'b0, min_block_q};

  always_comb begin
    fslot_ok = 1'b0;
    fslot    = '0;
    for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
      if (!fvalid_q[i]) begin
        fslot_ok = 1'b1;
        fslot    = FAW'(i);
      end
    end
    uslot_ok = 1'b0;
    uslot    = '0;
    for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
      if (!uvalid_q[i]) begin
        uslot_ok = 1'b1;
        uslot    = UAW'(i);
      end
    end
  end

  // Table writes, all in the update cycle.
  always_comb begin
    fw_en   = 1'b0;
    fw_addr = '0;
    fw_data = '0;
    uw_en   = 1'b0;
    uw_addr = uslot;
    uw_data = '0;
    if (state_q == S_DECIDE) begin
      if (mode_q == ModeAlloc) begin
        if (b_fnd_q && name_q != '0 && uslot_ok) begin
          fw_en   = 1'b1;
          fw_addr = b_idx_q;
          fw_data = '{start: b_start_q + ad_q, size: b_size_q - ad_q};
          uw_en   = 1'b1;
          uw_data = '{tag: name_q, start: b_start_q, size: ad_q};
        end
      end else if (z_q != '0) begin
        if (lo_fnd_q) begin
          fw_en   = 1'b1;
          fw_addr = lo_idx_q;
          fw_data = '{start: lo_start_q,
                      size: lo_size_q + z_q + (hi_fnd_q ? hi_size_q : 17'd0)};
        end else if (hi_fnd_q) begin
          fw_en   = 1'b1;
          fw_addr = hi_idx_q;
          fw_data = '{start: s_q, size: hi_size_q + z_q};
        end else if (fslot_ok) begin
          fw_en   = 1'b1;
          fw_addr = fslot;
          fw_data = '{start: s_q, size: z_q};
        end
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ridx_q      <= '0;
      rv_q        <= 1'b0;
      rvl_q       <= 1'b0;
      min_block_q <= MinBlockReset;
      fvalid_q    <= FREE_ENTRIES'(1);
      uvalid_q    <= '0;
      f0w_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
      mode_q      <= ModeAlloc;
      name_q      <= '0;
      ad_q        <= '0;
      b_fnd_q     <= 1'b0;
      b_idx_q     <= '0;
      b_start_q   <= '0;
      b_size_q    <= '0;
      u_fnd_q     <= 1'b0;
      u_idx_q     <= '0;
      s_q         <= '0;
      z_q         <= '0;
      lo_fnd_q    <= 1'b0;
      hi_fnd_q    <= 1'b0;
      lo_idx_q    <= '0;
      hi_idx_q    <= '0;
      lo_start_q  <= '0;
      lo_size_q   <= '0;
      hi_size_q   <= '0;
    end else begin
      if (cfg_we_i) min_block_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i && state_q != S_RESP) out_valid_q <= 1'b0;
      if (fw_en && fw_addr == '0) f0w_q <= 1'b1;

      rv_q   <= issue_f || issue_u;
      rvl_q  <= issue_f ? fvalid_q[cnt_q[FAW-1:0]] : issue_u && uvalid_q[cnt_q[UAW-1:0]];
      ridx_q <= cnt_q;
      if (issue_f || issue_u) cnt_q <= cnt_q + 1'b1;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= in_data_i.mode;
            name_q   <= in_data_i.job_name;
            ad_q     <= req_ad;
            cnt_q    <= '0;
            b_fnd_q  <= 1'b0;
            u_fnd_q  <= 1'b0;
            lo_fnd_q <= 1'b0;
            hi_fnd_q <= 1'b0;
            if (in_data_i.mode == ModeAlloc) begin
              state_q <= S_FSCAN;
            end else if (in_data_i.job_name == '0) begin
              res_q   <= '{status: StNotFound, block_start: '0, block_size: '0};
              state_q <= S_RESP;
            end else begin
              state_q <= S_USCAN;
            end
          end
        end
        S_USCAN: begin
          if (rv_q && rvl_q && !u_fnd_q && u_rd_q.tag == name_q) begin
            u_fnd_q <= 1'b1;
            u_idx_q <= ridx_q[UAW-1:0];
            s_q     <= u_rd_q.start;
            z_q     <= u_rd_q.size;
          end
          if (cnt_q == UN && !rv_q) begin
            cnt_q <= '0;
            if (!u_fnd_q) begin
              res_q   <= '{status: StNotFound, block_start: '0, block_size: '0};
              state_q <= S_RESP;
            end else if (z_q == '0) begin
              uvalid_q[u_idx_q] <= 1'b0;
              res_q   <= '{status: StOk, block_start: s_q, block_size: z_q};
              state_q <= S_RESP;
            end else begin
              state_q <= S_FSCAN;
            end
          end
        end
        S_FSCAN: begin
          if (rv_q && rvl_q) begin
            if (mode_q == ModeAlloc) begin
              if (f_size >= ad_q && (!b_fnd_q || f_size < b_size_q ||
                  (f_size == b_size_q && f_start < b_start_q))) begin
                b_fnd_q   <= 1'b1;
                b_idx_q   <= ridx_q[FAW-1:0];
                b_start_q <= f_start;
                b_size_q  <= f_size;
              end
            end else if (!lo_fnd_q && f_end == s_q) begin
              lo_fnd_q   <= 1'b1;
              lo_idx_q   <= ridx_q[FAW-1:0];
              lo_start_q <= f_start;
              lo_size_q  <= f_size;
            end else if (!hi_fnd_q && f_start == z_end) begin
              hi_fnd_q  <= 1'b1;
              hi_idx_q  <= ridx_q[FAW-1:0];
              hi_size_q <= f_size;
            end
          end
          if (cnt_q == FN && !rv_q) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          state_q <= S_RESP;
          if (mode_q == ModeAlloc) begin
            if (!b_fnd_q) begin
              res_q <= '{status: StNoFit, block_start: '0, block_size: '0};
            end else if (name_q == '0 || !uslot_ok) begin
              res_q <= '{status: StUsedFull, block_start: '0, block_size: '0};
            end else begin
              uvalid_q[uslot] <= 1'b1;
              if (b_size_q == ad_q) fvalid_q[b_idx_q] <= 1'b0;
              res_q <= '{status: StOk, block_start: b_start_q, block_size: ad_q};
            end
          end else if (!lo_fnd_q && !hi_fnd_q && !fslot_ok) begin
            res_q <= '{status: StFreeFull, block_start: '0, block_size: '0};
          end else begin
            uvalid_q[u_idx_q] <= 1'b0;
            if (lo_fnd_q && hi_fnd_q) fvalid_q[hi_idx_q] <= 1'b0;
            else if (!lo_fnd_q && !hi_fnd_q) fvalid_q[fslot] <= 1'b1;
            res_q <= '{status: StOk, block_start: s_q, block_size: z_q};
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
